// ===== sv/rwpvf_pkg.sv =====
// ----------------------------------------------------------------------------
// rwpvf_pkg
// Shared constants and types for the trimmed-mean window filter.
// ----------------------------------------------------------------------------
`default_nettype none
package rwpvf_pkg;
  localparam int unsigned WindowDepth = 8;
  localparam int unsigned SlotW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam int unsigned SumW = 16 + $clog2(WindowDepth) + 1;
  localparam int unsigned DevW = SumW + $clog2(WindowDepth) + 1;
  localparam int unsigned DistW = 2 * DevW + 1;
  localparam int unsigned Divisor = WindowDepth - 2;
  localparam int unsigned EntryW = 48;
  localparam int unsigned ThrW = 15;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(1);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] v;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] est_x;
    logic signed [15:0] est_y;
    logic signed [15:0] est_v;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/rwpvf_ram.sv =====
// ----------------------------------------------------------------------------
// rwpvf_ram
// Window store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module rwpvf_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [rwpvf_pkg::SlotW-1:0] waddr_i,
  input  wire rwpvf_pkg::entry_t        wdata_i,
  input  wire logic [rwpvf_pkg::SlotW-1:0] raddr_i,
  output rwpvf_pkg::entry_t             rdata_o
);
  import rwpvf_pkg::*;
  entry_t mem [WindowDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/rwpvf_div.sv =====
// ----------------------------------------------------------------------------
// rwpvf_div
// Divide by WindowDepth-2 by reciprocal multiplication, truncating toward zero;
// the operand is registered at start, then the quotient and done_o are registered.
// ----------------------------------------------------------------------------
`default_nettype none
module rwpvf_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [rwpvf_pkg::SumW-1:0] num_i,
  output logic                                done_o,
  output logic signed [15:0]                  quo_o
);
  import rwpvf_pkg::*;
  localparam int unsigned ShiftK = SumW - 1 + $clog2(Divisor);
  localparam int unsigned RecipW = ShiftK + 1;
  localparam int unsigned ProdW = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << ShiftK) + 64'(Divisor) - 64'd1) / 64'(Divisor));

  logic [SumW-1:0] mag_q, qmag, qneg;
  logic [ProdW-1:0] prod;
  logic neg_q, busy_q;

  assign prod = ProdW'(mag_q) * ProdW'(Recip);
  assign qmag = prod[ShiftK +: SumW];
  assign qneg = neg_q ? -qmag : qmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0;
    end else begin
      busy_q <= start_i; done_o <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[SumW-1];
      mag_q <= num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);
    end
    if (busy_q) quo_o <= qneg[15:0];
  end
endmodule
`default_nettype wire

// ===== sv/robust_window_position_velocity_filter_top.sv =====
// One sample is processed at a time: s_axis_tready is high only while idle.
// Steps: fill (every slot when priming), sum, distance, two drop passes, trimmed sum,
// three divides, output; a full output register holds the output step.
// Reset: control clears at once; the first sample fills every slot, no clearing pass.
// stop_threshold resets to 1.
// ----------------------------------------------------------------------------
// robust_window_position_velocity_filter_top
// Sliding-window trimmed-mean filter for position and speed samples.
// ----------------------------------------------------------------------------
`default_nettype none
module robust_window_position_velocity_filter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // sample_x, sample_y, sample_speed
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // estimate_x, estimate_y, estimate_speed
  output logic             m_axis_tuser,  // is_stopped
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_wdata_i
);
  import rwpvf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_FILL = 10'b0000000010, S_SUM  = 10'b0000000100,
    S_DIST = 10'b0000001000, S_DROP = 10'b0000010000, S_ACC  = 10'b0000100000,
    S_DVX  = 10'b0001000000, S_DVY  = 10'b0010000000, S_DVV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [ThrW-1:0] thr_q;
  logic primed_q, primed_d;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic pass_q, pass_d;
  logic [WindowDepth-1:0] drop_q, drop_d;
  logic signed [SumW-1:0] sx_q, sy_q, sv_q, sx_d, sy_d, sv_d;
  logic signed [SumW-1:0] ex_q, ey_q, ex_d, ey_d;
  logic signed [15:0] vmin_q, vmax_q, vmin_d, vmax_d;
  logic [DistW-1:0] dist_q [WindowDepth];
  logic [DistW-1:0] best_q, best_d, dnew;
  logic [SlotW-1:0] bidx_q, bidx_d;
  logic bvalid_q, bvalid_d;
  entry_t sample_q;
  result_t res_q, res_d, out_q;
  logic stop_q, stop_d, ovalid_d, ostop_q;

  logic we;
  logic [SlotW-1:0] waddr, raddr, ridx, rpos;
  entry_t rdata;
  logic div_start, div_done;
  logic signed [SumW-1:0] div_num;
  logic signed [15:0] div_q;
  logic signed [DevW-1:0] dx, dy;
  logic signed [2*DevW-1:0] px, py;

  rwpvf_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(sample_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  rwpvf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .done_o(div_done), .quo_o(div_q)
  );

  // RAM slot of window position i counted from the oldest entry at base, wrapping
  function automatic logic [SlotW-1:0] slot_of(logic [SlotW-1:0] base, logic [CntW-1:0] i);
    logic [SlotW:0] s;
    s = {1'b0, base} + (SlotW+1)'(i);
    if (s >= (SlotW+1)'(WindowDepth)) s = s - (SlotW+1)'(WindowDepth);
    return s[SlotW-1:0];
  endfunction

  assign raddr = slot_of(oldest_q, cnt_q);
  assign ridx = (cnt_q == '0) ? '0 : SlotW'(cnt_q - 1'b1);
  assign rpos = ridx;
  assign dx = DevW'($signed(rdata.x)) * DevW'(WindowDepth) - DevW'(sx_q);
  assign dy = DevW'($signed(rdata.y)) * DevW'(WindowDepth) - DevW'(sy_q);
  assign px = dx * dx;
  assign py = dy * dy;
  assign dnew = DistW'(px) + DistW'(py);
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q; primed_d = primed_q; oldest_d = oldest_q; cnt_d = cnt_q;
    pass_d = pass_q; drop_d = drop_q; sx_d = sx_q; sy_d = sy_q; sv_d = sv_q;
    ex_d = ex_q; ey_d = ey_q; vmin_d = vmin_q; vmax_d = vmax_q;
    best_d = best_q; bidx_d = bidx_q; bvalid_d = bvalid_q; res_d = res_q;
    stop_d = stop_q; ovalid_d = 1'b0; we = 1'b0; waddr = oldest_q;
    div_start = 1'b0; div_num = sx_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        cnt_d = '0;
        state_d = primed_q ? S_FILL : S_FILL;
      end
      S_FILL: begin
        we = 1'b1;
        if (!primed_q) begin
          waddr = SlotW'(cnt_q);
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(WindowDepth - 1)) begin
            primed_d = 1'b1; oldest_d = '0; cnt_d = '0; state_d = S_SUM;
            sx_d = '0; sy_d = '0; sv_d = '0;
          end
        end else begin
          oldest_d = (oldest_q == SlotW'(WindowDepth - 1)) ? '0 : oldest_q + 1'b1;
          cnt_d = '0; state_d = S_SUM; sx_d = '0; sy_d = '0; sv_d = '0;
        end
      end
      S_SUM: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          sx_d = sx_q + SumW'(rdata.x); sy_d = sy_q + SumW'(rdata.y);
          sv_d = sv_q + SumW'(rdata.v);
          if (cnt_q == CntW'(1) || rdata.v < vmin_q) vmin_d = rdata.v;
          if (cnt_q == CntW'(1) || rdata.v > vmax_q) vmax_d = rdata.v;
        end
        if (cnt_q == CntW'(WindowDepth)) begin
          cnt_d = '0; state_d = S_DIST;
        end
      end
      S_DIST: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WindowDepth)) begin
          cnt_d = '0; state_d = S_DROP; pass_d = 1'b0; drop_d = '0;
          bvalid_d = 1'b0;
        end
      end
      S_DROP: begin
        cnt_d = cnt_q + 1'b1;
        if (!drop_q[SlotW'(cnt_q)] && (!bvalid_q || dist_q[SlotW'(cnt_q)] > best_q)) begin
          best_d = dist_q[SlotW'(cnt_q)]; bidx_d = SlotW'(cnt_q); bvalid_d = 1'b1;
        end
        if (cnt_q == CntW'(WindowDepth - 1)) begin
          drop_d = drop_q;
          if (!drop_q[SlotW'(cnt_q)] && (!bvalid_q || dist_q[SlotW'(cnt_q)] > best_q))
            drop_d[SlotW'(cnt_q)] = 1'b1;
          else drop_d[bidx_q] = 1'b1;
          cnt_d = '0; bvalid_d = 1'b0; pass_d = 1'b1;
          if (pass_q) begin
            state_d = S_ACC; ex_d = '0; ey_d = '0;
          end
        end
      end
      S_ACC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0 && !drop_q[rpos]) begin
          ex_d = ex_q + SumW'(rdata.x); ey_d = ey_q + SumW'(rdata.y);
        end
        if (cnt_q == CntW'(WindowDepth)) begin
          state_d = S_DVX; div_start = 1'b1; div_num = ex_d;
        end
      end
      S_DVX: if (div_done) begin
        res_d.est_x = div_q; div_start = 1'b1; div_num = ey_q; state_d = S_DVY;
      end
      S_DVY: if (div_done) begin
        res_d.est_y = div_q; div_start = 1'b1;
        div_num = sv_q - SumW'(vmin_q) - SumW'(vmax_q); state_d = S_DVV;
      end
      S_DVV: if (div_done) begin
        res_d.est_v = div_q;
        stop_d = $signed({1'b0, thr_q}) > 17'(div_q);
        state_d = S_OUT;
      end
      S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; thr_q <= ThrReset; primed_q <= 1'b0; oldest_q <= '0;
      cnt_q <= '0; pass_q <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d; primed_q <= primed_d; oldest_q <= oldest_d;
      cnt_q <= cnt_d; pass_q <= pass_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (ovalid_d) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16], v: s_axis_tdata[47:32]};
    end
    drop_q <= drop_d; sx_q <= sx_d; sy_q <= sy_d; sv_q <= sv_d;
    ex_q <= ex_d; ey_q <= ey_d; vmin_q <= vmin_d; vmax_q <= vmax_d;
    best_q <= best_d; bidx_q <= bidx_d; bvalid_q <= bvalid_d;
    res_q <= res_d; stop_q <= stop_d;
    if (ovalid_d) begin
      out_q <= res_q; ostop_q <= stop_q;
    end
    if (state_q == S_DIST && cnt_q != '0) dist_q[rpos] <= dnew;
  end

  assign m_axis_tdata = {out_q.est_v, out_q.est_y, out_q.est_x};
  assign m_axis_tuser = ostop_q;
endmodule
`default_nettype wire

// ===== sv/rwpvf_checker.sv =====
// ----------------------------------------------------------------------------
// rwpvf_port_checker
// Port-level checks for the window filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rwpvf_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)) else $error("output beat changed while stalled");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tuser}))
    else $error("unknown output beat");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample overlap");
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind robust_window_position_velocity_filter_top rwpvf_port_checker u_chk (.*);
`default_nettype wire
